// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sparse CSC transpose
// Beat payloads, entry records, action and result codes, register indexes.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int DIM_W   = 11;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 64;
    localparam int PTR_W   = 13;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 3;
    localparam int CFG_I_W = 1;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_END   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FETCH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PTR       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE_OK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE_DROP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd4;

    localparam logic [CFG_I_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_I_W-1:0] CFG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] col_index;
        logic [IDX_W-1:0] row_index;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [PTR_W-1:0]  pointer_value;
        logic [IDX_W-1:0]  out_row_index;
        logic [VAL_W-1:0]  out_value;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [VAL_W-1:0] value;
    } t_tr_entry;

    typedef struct packed {
        logic load;
        logic clear;
        logic rd_en;
    } t_ld_ctrl;

endpackage

// ===== rtl/sct_loader.sv =====
// ----------------------------------------------------------------------------
// sct_loader: input entry store of the sparse CSC transpose
// Checks each loaded nonzero, appends those that pass to the entry memory and keeps the
// entry count and the drop flag of the load phase.
// ----------------------------------------------------------------------------
module sct_loader #(
    parameter int MAX_NNZ = 4096
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  sct_pkg::t_ld_ctrl                           i_ctrl,
    input  sct_pkg::t_entry                             i_item,
    input  logic [((MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1)-1:0] i_rd_addr,
    input  logic [sct_pkg::DIM_W-1:0]                   i_num_rows,
    input  logic [sct_pkg::DIM_W-1:0]                   i_num_cols,
    output logic [$clog2(MAX_NNZ + 1)-1:0]              o_count,
    output logic                                        o_drop,
    output sct_pkg::t_entry                             o_rd_data
);

    localparam int Cw  = $clog2(MAX_NNZ + 1);
    localparam int AwN = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;

    sct_pkg::t_entry               r_mem [MAX_NNZ];
    sct_pkg::t_entry               r_rd_data;
    logic [Cw-1:0]                 r_count;
    logic                          r_drop;
    logic [sct_pkg::IDX_W-1:0]     r_last_col;
    logic                          ok;

    assign ok = (r_count < Cw'(MAX_NNZ))
             && ({1'b0, i_item.row} < i_num_rows)
             && ({1'b0, i_item.col} < i_num_cols)
             && ((r_count == '0) || (i_item.col >= r_last_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (i_ctrl.load) begin
            if (ok) begin
                r_count <= r_count + Cw'(1);
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && ok) begin
            r_mem[AwN'(r_count)] <= i_item;
            r_last_col           <= i_item.col;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_count   = r_count;
    assign o_drop    = r_drop;
    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sparse_csc_transpose.sv =====
// ----------------------------------------------------------------------------
// sparse_csc_transpose: counting-sort transpose of a CSC sparse matrix
// Loads nonzeros, transposes them with a sequencer over one offset table,
// then returns column end pointers, entries and a done result on fetches.
// ----------------------------------------------------------------------------
//  Channel   Ports                             Beat
//  command   i_start, o_busy, i_data           one action with its nonzero
//  result    o_valid, o_result                 one result, one cycle wide
//  config    i_cfg_we, i_cfg_index, i_cfg_data one register write
//
//  A load is taken in the idle state and does not raise busy. A fetch while
//  loading answers in the next cycle; a fetch while draining holds busy in
//  the fetch state for the memory read and answers in the cycle after it.
//  The end command runs the sequencer: clear the table, count per row, sum
//  the offsets, scatter the entries. Reset needs no clearing pass; the table
//  is zeroed at the start of each transpose. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sparse_csc_transpose #(
    parameter int MAX_DIM = 1024,
    parameter int MAX_NNZ = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  sct_pkg::t_in_item                i_data,
    output logic                             o_valid,
    output sct_pkg::t_out_item               o_result,
    input  logic                             i_cfg_we,
    input  logic [sct_pkg::CFG_I_W-1:0]      i_cfg_index,
    input  logic [sct_pkg::DIM_W-1:0]        i_cfg_data
);

    localparam int DimW       = sct_pkg::DIM_W;
    localparam int PtrW       = sct_pkg::PTR_W;
    localparam int MaxDimClip = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
    localparam int Cw         = $clog2(MAX_NNZ + 1);
    localparam int AwN        = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    localparam int AwD        = $clog2(MAX_DIM);
    localparam int Pw         = $clog2(MaxDimClip + MAX_NNZ + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_CLEAR   = 11'b000_0000_0010,
        S_CNT_RD  = 11'b000_0000_0100,
        S_CNT_CHK = 11'b000_0000_1000,
        S_CNT_UPD = 11'b000_0001_0000,
        S_PFX_RD  = 11'b000_0010_0000,
        S_PFX_WR  = 11'b000_0100_0000,
        S_SCT_RD  = 11'b000_1000_0000,
        S_SCT_CHK = 11'b001_0000_0000,
        S_SCT_UPD = 11'b010_0000_0000,
        S_FETCH   = 11'b100_0000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_drain, n_drain;
    logic [Cw-1:0]               r_idx, n_idx;
    logic [DimW-1:0]             r_row_idx, n_row_idx;
    logic [Cw-1:0]               r_sum, n_sum;
    logic                        r_drop, n_drop;
    logic [Cw-1:0]               r_entries, n_entries;
    logic [Pw-1:0]               r_cursor, n_cursor;
    logic                        r_valid, n_valid;
    sct_pkg::t_out_item          r_out, n_out;
    logic [DimW-1:0]             r_num_rows, r_num_cols;

    logic [Cw-1:0]               r_tbl [MAX_DIM];
    logic [Cw-1:0]               r_tbl_rdata;
    sct_pkg::t_tr_entry          r_ost [MAX_NNZ];
    sct_pkg::t_tr_entry          r_ost_rdata;

    logic                        tbl_we, tbl_re;
    logic [AwD-1:0]              tbl_waddr, tbl_raddr;
    logic [Cw-1:0]               tbl_wdata;
    logic                        ost_we, ost_re;
    logic [AwN-1:0]              ost_waddr, ost_raddr;
    sct_pkg::t_tr_entry          ost_wdata;

    sct_pkg::t_ld_ctrl           ld_ctrl;
    sct_pkg::t_entry             ld_item;
    sct_pkg::t_entry             ld_rd;
    logic [AwN-1:0]              ld_addr;
    logic [Cw-1:0]               ld_count;
    logic                        ld_drop;

    logic [DimW-1:0]             eff_nr, eff_nc;
    logic                        accept, ent_ok;
    logic [Pw-1:0]               cur_k;

    assign eff_nr = (r_num_rows > DimW'(MaxDimClip)) ? DimW'(MaxDimClip) : r_num_rows;
    assign eff_nc = (r_num_cols > DimW'(MaxDimClip)) ? DimW'(MaxDimClip) : r_num_cols;
    assign accept = i_start && !o_busy;
    assign ent_ok = ({1'b0, ld_rd.row} < eff_nr) && ({1'b0, ld_rd.col} < eff_nc);
    assign cur_k  = r_cursor - Pw'(eff_nr);

    assign ld_item = '{col: i_data.col_index, row: i_data.row_index, value: i_data.value};

    sct_loader #(
        .MAX_NNZ (MAX_NNZ)
    ) u_loader (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ld_ctrl),
        .i_item     (ld_item),
        .i_rd_addr  (ld_addr),
        .i_num_rows (eff_nr),
        .i_num_cols (eff_nc),
        .o_count    (ld_count),
        .o_drop     (ld_drop),
        .o_rd_data  (ld_rd)
    );

    always_comb begin
        n_state   = r_state;
        n_drain   = r_drain;
        n_idx     = r_idx;
        n_row_idx = r_row_idx;
        n_sum     = r_sum;
        n_drop    = r_drop;
        n_entries = r_entries;
        n_cursor  = r_cursor;
        n_valid   = 1'b0;
        n_out     = r_out;
        tbl_we    = 1'b0;
        tbl_waddr = AwD'(ld_rd.row);
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = AwD'(ld_rd.row);
        ost_we    = 1'b0;
        ost_waddr = AwN'(r_tbl_rdata);
        ost_wdata = '{row: ld_rd.col, value: ld_rd.value};
        ost_re    = 1'b0;
        ost_raddr = AwN'(cur_k);
        ld_ctrl   = '0;
        ld_addr   = AwN'(r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_data.action)
                        sct_pkg::ACT_LOAD: begin
                            ld_ctrl.load = !r_drain;
                        end
                        sct_pkg::ACT_END: begin
                            if (!r_drain) begin
                                n_state   = S_CLEAR;
                                n_row_idx = '0;
                            end
                        end
                        sct_pkg::ACT_FETCH: begin
                            if (!r_drain) begin
                                n_valid = 1'b1;
                                n_out   = '0;
                                n_out.result_kind = sct_pkg::KIND_NONE;
                            end else begin
                                tbl_re    = (r_cursor < Pw'(eff_nr));
                                tbl_raddr = AwD'(r_cursor);
                                ost_re    = !(r_cursor < Pw'(eff_nr));
                                n_state   = S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_row_idx == eff_nr) begin
                    n_state = S_CNT_RD;
                    n_idx   = '0;
                end else begin
                    tbl_we    = 1'b1;
                    tbl_waddr = AwD'(r_row_idx);
                    n_row_idx = r_row_idx + DimW'(1);
                end
            end
            S_CNT_RD: begin
                if (r_idx == ld_count) begin
                    n_state   = S_PFX_RD;
                    n_row_idx = '0;
                    n_sum     = '0;
                end else begin
                    ld_ctrl.rd_en = 1'b1;
                    n_state       = S_CNT_CHK;
                end
            end
            S_CNT_CHK: begin
                if (ent_ok) begin
                    tbl_re  = 1'b1;
                    n_state = S_CNT_UPD;
                end else begin
                    n_drop  = 1'b1;
                    n_idx   = r_idx + Cw'(1);
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_UPD: begin
                tbl_we    = 1'b1;
                tbl_wdata = r_tbl_rdata + Cw'(1);
                n_idx     = r_idx + Cw'(1);
                n_state   = S_CNT_RD;
            end
            S_PFX_RD: begin
                if (r_row_idx == eff_nr) begin
                    n_state = S_SCT_RD;
                    n_idx   = '0;
                end else begin
                    tbl_re    = 1'b1;
                    tbl_raddr = AwD'(r_row_idx);
                    n_state   = S_PFX_WR;
                end
            end
            S_PFX_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = AwD'(r_row_idx);
                tbl_wdata = r_sum;
                n_sum     = r_sum + r_tbl_rdata;
                n_row_idx = r_row_idx + DimW'(1);
                n_state   = S_PFX_RD;
            end
            S_SCT_RD: begin
                if (r_idx == ld_count) begin
                    n_entries = r_sum;
                    n_cursor  = '0;
                    n_drain   = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    ld_ctrl.rd_en = 1'b1;
                    n_state       = S_SCT_CHK;
                end
            end
            S_SCT_CHK: begin
                if (ent_ok) begin
                    tbl_re  = 1'b1;
                    n_state = S_SCT_UPD;
                end else begin
                    n_idx   = r_idx + Cw'(1);
                    n_state = S_SCT_RD;
                end
            end
            S_SCT_UPD: begin
                tbl_we    = 1'b1;
                tbl_wdata = r_tbl_rdata + Cw'(1);
                ost_we    = 1'b1;
                n_idx     = r_idx + Cw'(1);
                n_state   = S_SCT_RD;
            end
            S_FETCH: begin
                n_valid = 1'b1;
                n_out   = '0;
                n_state = S_IDLE;
                if (r_cursor < Pw'(eff_nr)) begin
                    n_out.result_kind   = sct_pkg::KIND_PTR;
                    n_out.pointer_value = PtrW'(r_tbl_rdata);
                    n_cursor            = r_cursor + Pw'(1);
                end else if (cur_k < Pw'(r_entries)) begin
                    n_out.result_kind   = sct_pkg::KIND_ENTRY;
                    n_out.out_row_index = r_ost_rdata.row;
                    n_out.out_value     = r_ost_rdata.value;
                    n_cursor            = r_cursor + Pw'(1);
                end else begin
                    n_out.result_kind   = (r_drop || ld_drop) ? sct_pkg::KIND_DONE_DROP
                                                              : sct_pkg::KIND_DONE_OK;
                    n_out.pointer_value = PtrW'(r_entries);
                    n_out.last          = 1'b1;
                    n_drain             = 1'b0;
                    n_cursor            = '0;
                    n_drop              = 1'b0;
                    n_entries           = '0;
                    ld_ctrl.clear       = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_drain    <= 1'b0;
            r_idx      <= '0;
            r_row_idx  <= '0;
            r_sum      <= '0;
            r_drop     <= 1'b0;
            r_entries  <= '0;
            r_cursor   <= '0;
            r_valid    <= 1'b0;
            r_num_rows <= DimW'(1);
            r_num_cols <= DimW'(1);
        end else begin
            r_state   <= n_state;
            r_drain   <= n_drain;
            r_idx     <= n_idx;
            r_row_idx <= n_row_idx;
            r_sum     <= n_sum;
            r_drop    <= n_drop;
            r_entries <= n_entries;
            r_cursor  <= n_cursor;
            r_valid   <= n_valid;
            if (i_cfg_we && !r_drain) begin
                if (i_cfg_index == sct_pkg::CFG_NUM_ROWS) begin
                    r_num_rows <= i_cfg_data;
                end
                if (i_cfg_index == sct_pkg::CFG_NUM_COLS) begin
                    r_num_cols <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            r_tbl_rdata <= r_tbl[tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ost_we) begin
            r_ost[ost_waddr] <= ost_wdata;
        end
        if (ost_re) begin
            r_ost_rdata <= r_ost[ost_raddr];
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state == S_FETCH)
                     || $past(accept && (i_data.action == sct_pkg::ACT_FETCH))))
        else $error("result strobe without a fetch");

    a_done_leaves_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> !r_drain)
        else $error("drain phase still set after the done result");

    a_scatter_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCT_UPD) |-> (r_tbl_rdata < r_sum))
        else $error("scatter position beyond the entry total");

    a_entries_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_entries <= ld_count))
        else $error("transposed entry count exceeds loaded count");

endmodule
